FILE: design/mi3_pkg.sv
// mi3_pkg: payload types and fixed formats for the 3x3 matrix inverse
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

    localparam int ELEM_BITS = 32;

    typedef struct packed {
        logic signed [ELEM_BITS-1:0] a_00;
        logic signed [ELEM_BITS-1:0] a_01;
        logic signed [ELEM_BITS-1:0] a_02;
        logic signed [ELEM_BITS-1:0] a_10;
        logic signed [ELEM_BITS-1:0] a_11;
        logic signed [ELEM_BITS-1:0] a_12;
        logic signed [ELEM_BITS-1:0] a_20;
        logic signed [ELEM_BITS-1:0] a_21;
        logic signed [ELEM_BITS-1:0] a_22;
    } mat_in_t;

    typedef struct packed {
        logic signed [ELEM_BITS-1:0] inv_00;
        logic signed [ELEM_BITS-1:0] inv_01;
        logic signed [ELEM_BITS-1:0] inv_02;
        logic signed [ELEM_BITS-1:0] inv_10;
        logic signed [ELEM_BITS-1:0] inv_11;
        logic signed [ELEM_BITS-1:0] inv_12;
        logic signed [ELEM_BITS-1:0] inv_20;
        logic signed [ELEM_BITS-1:0] inv_21;
        logic signed [ELEM_BITS-1:0] inv_22;
        logic                        singular;
    } mat_out_t;

endpackage

`default_nettype wire

FILE: design/mi3_div.sv
// mi3_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing; used by matrix_inverse_3x3
`timescale 1ns / 1ps
`default_nettype none

module mi3_div #(
    parameter int NUM_BITS = 128,
    parameter int DEN_BITS = 96,
    parameter int Q_BITS   = 34,
    parameter int TAG_BITS = 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    input  wire logic [TAG_BITS-1:0] tag_in,
    output logic                     out_valid,
    output logic [Q_BITS-1:0]        quo,
    output logic                     round_up,
    output logic [TAG_BITS-1:0]      tag_out
);

    // numerator below den * 2^Q_BITS is required (caller flags overflow and saturates the result)
    localparam int R_BITS = DEN_BITS + 1;

    logic                v_reg   [0:Q_BITS];
    logic [R_BITS-1:0]   r_reg   [0:Q_BITS];
    logic [NUM_BITS-1:0] n_reg   [0:Q_BITS];
    logic [DEN_BITS-1:0] d_reg   [0:Q_BITS];
    logic [Q_BITS-1:0]   q_reg   [0:Q_BITS];
    logic [TAG_BITS-1:0] t_reg   [0:Q_BITS];

    always_comb
    begin
        v_reg[0] = in_valid;
        r_reg[0] = R_BITS'(num >> Q_BITS);
        n_reg[0] = num;
        d_reg[0] = den;
        q_reg[0] = '0;
        t_reg[0] = tag_in;
    end

    for (genvar s = 0; s < Q_BITS; s++)
    begin : g_stage
        logic [R_BITS-1:0] sh;
        logic [R_BITS:0]   diff;
        always_comb
        begin
            sh   = {r_reg[s][R_BITS-2:0], n_reg[s][Q_BITS-1-s]};
            diff = {1'b0, sh} - {2'b00, d_reg[s]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else
                v_reg[s+1] <= v_reg[s];
        end
        always_ff @(posedge clk)
        begin
            r_reg[s+1] <= diff[R_BITS] ? sh : diff[R_BITS-1:0];
            q_reg[s+1] <= {q_reg[s][Q_BITS-2:0], ~diff[R_BITS]};
            n_reg[s+1] <= n_reg[s];
            d_reg[s+1] <= d_reg[s];
            t_reg[s+1] <= t_reg[s];
        end
    end

    always_comb
    begin
        out_valid = v_reg[Q_BITS];
        quo       = q_reg[Q_BITS];
        tag_out   = t_reg[Q_BITS];
        round_up  = ({r_reg[Q_BITS], 1'b0} >= {2'b00, d_reg[Q_BITS]});
    end

endmodule

`default_nettype wire

FILE: design/matrix_inverse_3x3.sv
// matrix_inverse_3x3: adjugate inverse of a 3x3 fixed-point matrix
// depends on mi3_pkg and mi3_div
//
// channel  | handshake     | payload
// ---------+---------------+---------------
// input    | start / busy  | a (mat_in_t)
// result   | done strobe   | result (mat_out_t)
//
// one word enters every cycle; busy is always low
// from the accepting edge to the edge that takes the result, the pipeline holds:
// 7 stages for cofactors, determinant and magnitudes, W+2 divider stages
// (one per quotient bit), 1 output register
// reset clears the valid bits only; results cannot be stalled
`timescale 1ns / 1ps
`default_nettype none

module matrix_inverse_3x3
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire mat_in_t a,
    output logic      done,
    output mat_out_t  result
);

    localparam int W  = ELEM_BITS;
    localparam int PW = 2 * W;          // product
    localparam int CW = 2 * W + 1;      // cofactor
    localparam int LB = CW - W;         // low cofactor slice
    localparam int LW = W + LB + 1;     // element times low slice
    localparam int TW = 3 * W + 1;      // a * cofactor
    localparam int DW = 3 * W + 3;      // determinant
    localparam int NW = CW + 2 * FRAC_BITS; // shifted numerator magnitude
    localparam int QB = W + 2;          // quotient bits kept (saturation margin)

    // stage 1: register inputs
    logic        v1_reg;
    mat_in_t     m1_reg;
    // stage 2: 18 products
    logic                 v2_reg;
    logic signed [PW-1:0] p_reg [0:17];
    mat_in_t              m2_reg;
    // stage 3: cofactors
    logic                 v3_reg;
    logic signed [CW-1:0] c3_reg [0:8];
    mat_in_t              m3_reg;
    // stage 4: first-row partial products with adj column 0
    logic                 v4_reg;
    logic signed [PW-1:0] ph4_reg [0:2];
    logic signed [LW-1:0] pl4_reg [0:2];
    logic signed [CW-1:0] c4_reg [0:8];
    // stage 5: first-row products
    logic                 v5_reg;
    logic signed [TW-1:0] t5_reg [0:2];
    logic signed [CW-1:0] c5_reg [0:8];
    // stage 6: determinant
    logic                 v6_reg;
    logic signed [DW-1:0] d6_reg;
    logic signed [CW-1:0] c6_reg [0:8];
    // stage 7: magnitudes
    logic                 v7_reg;
    logic [DW-1:0]        dm7_reg;
    logic                 ds7_reg;
    logic                 dz7_reg;
    logic [CW-1:0]        am7_reg [0:8];
    logic                 as7_reg [0:8];

    logic signed [W-1:0] e [0:8];
    always_comb
    begin
        e[0] = m1_reg.a_00; e[1] = m1_reg.a_01; e[2] = m1_reg.a_02;
        e[3] = m1_reg.a_10; e[4] = m1_reg.a_11; e[5] = m1_reg.a_12;
        e[6] = m1_reg.a_20; e[7] = m1_reg.a_21; e[8] = m1_reg.a_22;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0; v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start; v2_reg <= v1_reg; v3_reg <= v2_reg;
            v4_reg <= v3_reg; v5_reg <= v4_reg; v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= a;
        m2_reg <= m1_reg;
        m3_reg <= m2_reg;
        // cofactor pairs, element indices r*3+c
        p_reg[0]  <= e[4] * e[8]; p_reg[1]  <= e[5] * e[7];
        p_reg[2]  <= e[2] * e[7]; p_reg[3]  <= e[1] * e[8];
        p_reg[4]  <= e[1] * e[5]; p_reg[5]  <= e[2] * e[4];
        p_reg[6]  <= e[5] * e[6]; p_reg[7]  <= e[3] * e[8];
        p_reg[8]  <= e[0] * e[8]; p_reg[9]  <= e[2] * e[6];
        p_reg[10] <= e[2] * e[3]; p_reg[11] <= e[0] * e[5];
        p_reg[12] <= e[3] * e[7]; p_reg[13] <= e[4] * e[6];
        p_reg[14] <= e[1] * e[6]; p_reg[15] <= e[0] * e[7];
        p_reg[16] <= e[0] * e[4]; p_reg[17] <= e[1] * e[3];
        for (int k = 0; k < 9; k++)
            c3_reg[k] <= CW'(p_reg[2*k]) - CW'(p_reg[2*k+1]);
        // cofactor split into signed high and unsigned low slices
        ph4_reg[0] <= m3_reg.a_00 * $signed(c3_reg[0][CW-1:LB]);
        ph4_reg[1] <= m3_reg.a_01 * $signed(c3_reg[3][CW-1:LB]);
        ph4_reg[2] <= m3_reg.a_02 * $signed(c3_reg[6][CW-1:LB]);
        pl4_reg[0] <= m3_reg.a_00 * $signed({1'b0, c3_reg[0][LB-1:0]});
        pl4_reg[1] <= m3_reg.a_01 * $signed({1'b0, c3_reg[3][LB-1:0]});
        pl4_reg[2] <= m3_reg.a_02 * $signed({1'b0, c3_reg[6][LB-1:0]});
        c4_reg <= c3_reg;
        for (int k = 0; k < 3; k++)
            t5_reg[k] <= (TW'(ph4_reg[k]) <<< LB) + TW'(pl4_reg[k]);
        c5_reg <= c4_reg;
        d6_reg <= DW'(t5_reg[0]) + DW'(t5_reg[1]) + DW'(t5_reg[2]);
        c6_reg <= c5_reg;
        ds7_reg <= d6_reg[DW-1];
        dz7_reg <= (d6_reg == '0);
        dm7_reg <= d6_reg[DW-1] ? DW'(-d6_reg) : DW'(d6_reg);
        for (int k = 0; k < 9; k++)
        begin
            as7_reg[k] <= c6_reg[k][CW-1];
            am7_reg[k] <= c6_reg[k][CW-1] ? CW'(-c6_reg[k]) : CW'(c6_reg[k]);
        end
    end

    // nine dividers; tag carries the result sign and singular flag
    logic [8:0]    dv_v;
    logic [QB-1:0] dv_q [0:8];
    logic [8:0]    dv_r;
    logic [10:0]   dv_t [0:8];

    for (genvar k = 0; k < 9; k++)
    begin : g_div
        mi3_div #(
            .NUM_BITS(NW),
            .DEN_BITS(DW),
            .Q_BITS  (QB),
            .TAG_BITS(11)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (v7_reg),
            .num      ({am7_reg[k], {(2*FRAC_BITS){1'b0}}}),
            .den      (dz7_reg ? DW'(1) : dm7_reg),
            .tag_in   ({9'd0, dz7_reg, as7_reg[k] ^ ds7_reg}),
            .out_valid(dv_v[k]),
            .quo      (dv_q[k]),
            .round_up (dv_r[k]),
            .tag_out  (dv_t[k])
        );
    end

    // quotient too wide for the divider: saturate
    logic [8:0]     ov_reg [0:QB-1];
    logic [8:0]     ov_in;
    always_comb
    begin
        for (int k = 0; k < 9; k++)
            ov_in[k] = (DW'({am7_reg[k], {(2*FRAC_BITS){1'b0}}} >> QB) >= dm7_reg)
                       && !dz7_reg;
    end
    always_ff @(posedge clk)
    begin
        ov_reg[0] <= ov_in;
        for (int s = 1; s < QB; s++)
            ov_reg[s] <= ov_reg[s-1];
    end

    // output stage: round, saturate, sign, zero if singular
    logic     out_v_reg;
    mat_out_t out_reg;
    logic signed [W-1:0] fin [0:8];
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            logic [QB:0] mag;
            logic        neg;
            logic [QB:0] lim;
            mag = {1'b0, dv_q[k]} + (QB+1)'(dv_r[k]);
            neg = dv_t[k][0];
            lim = (QB+1)'(1) << (W - 1);
            if (!neg)
                lim = lim - 1'b1;
            if (ov_reg[QB-1][k] || mag > lim)
                mag = lim;
            if (neg)
                mag = -mag;
            fin[k] = dv_t[k][1] ? '0 : W'(mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= dv_v[0];
    end

    always_ff @(posedge clk)
    begin
        out_reg.inv_00 <= fin[0]; out_reg.inv_01 <= fin[1]; out_reg.inv_02 <= fin[2];
        out_reg.inv_10 <= fin[3]; out_reg.inv_11 <= fin[4]; out_reg.inv_12 <= fin[5];
        out_reg.inv_20 <= fin[6]; out_reg.inv_21 <= fin[7]; out_reg.inv_22 <= fin[8];
        out_reg.singular <= dv_t[0][1];
    end

    assign busy   = 1'b0;
    assign done   = out_v_reg;
    assign result = out_reg;

    // singular results carry all-zero elements (checked on inv_00 and inv_11)
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.singular |-> result.inv_00 == '0 && result.inv_11 == '0)
        else $error("singular result not zero");
    // dividers stay in step
    a_div_lock: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v == '0 || dv_v == '1)
        else $error("divider lanes out of step");
    // each done follows a valid in the final stage of divider 0
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(dv_v[0]))
        else $error("done without divider result");

endmodule

`default_nettype wire
